>>> src/tcli_pkg.sv
// Shared types and constants for the transpose cycle-leader index engine.
// No dependencies; every other file imports this package.
package tcli_pkg;

  localparam int unsigned IDX_W      = 32;  // width of element and result indices
  localparam int unsigned CFG_DATA_W = 16;  // widest configuration register
  localparam int unsigned CFG_IDX_W  = 1;   // register index width

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DIM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_DIM = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_CHECK,
    S_FIX,
    S_FWD_WAIT,
    S_INV_WAIT,
    S_WALK_TEST,
    S_WALK_WAIT,
    S_DONE
  } seq_state_e;

  typedef enum logic {
    MM_DBL,
    MM_ADD
  } mm_phase_e;

endpackage

>>> src/tcli_if.sv
// Valid/ready channel interfaces for the index engine's input and result words.
// Depends on tcli_pkg for the index width.
interface tcli_in_if
  import tcli_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] elem_index;

  modport source (output valid, output elem_index, input ready);
  modport sink   (input valid, input elem_index, output ready);
endinterface

interface tcli_out_if
  import tcli_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] forward_index;
  logic [IDX_W-1:0] inverse_index;
  logic             is_leader;
  logic             out_of_range;

  modport source (output valid, output forward_index, output inverse_index,
                  output is_leader, output out_of_range, input ready);
  modport sink   (input valid, input forward_index, input inverse_index,
                  input is_leader, input out_of_range, output ready);
endinterface

>>> src/transpose_cycle_leader_index_top.sv
// Index engine for an in-place matrix transpose by cycle leaders.
// Channels: in_ch_i takes one elem_index word; out_ch_o returns one word with
// forward_index (index * first_dim mod L), inverse_index (index * second_dim
// mod L), is_leader (index is the smallest of its permutation cycle) and
// out_of_range (index above L), where L = first_dim * second_dim - 1.
// Configuration: write first_dim (index 0) and second_dim (index 1) through
// cfg_we_i / cfg_idx_i / cfg_wdata_i while the engine is idle; low DIM_BITS
// bits are kept. Both reset to 1.
// Flow: one word at a time. Each modular multiply runs on the shared unit with one
// doubling step per multiplier bit and one add step per set bit (DW = DIM_BITS bits,
// at most 16). An item passes the range check (S_PROD, S_CHECK, S_FIX), two multiplies,
// and one multiply and one test per step of its cycle walk, then a final test
// and an unload step; the walk stops at the index itself or at the first member
// below it, so leaders of long cycles are slowest.
// Out-of-range and last-index words skip the multiplies.
// The result sits in an output register; the next word is accepted while it
// waits, and a stalled receiver only holds the engine once a second result
// is ready. Reset clears the control state and drops any pending word.
// Depends on tcli_pkg, tcli_if, tcli_cfg_regs, tcli_mulmod and tcli_seq.
module transpose_cycle_leader_index_top
  import tcli_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tcli_in_if.sink               in_ch_i,
  tcli_out_if.source            out_ch_o
);

  // the write port carries 16 bits, so wider dimensions never hold more
  localparam int unsigned DW = (DIM_BITS < CFG_DATA_W) ? DIM_BITS : CFG_DATA_W;
  localparam int unsigned LW = 2 * DW;

  logic [DW-1:0] first_dim, second_dim;
  logic          mm_start, mm_done;
  logic [LW-1:0] mm_x, mm_m, mm_res;
  logic [DW-1:0] mm_y;

  tcli_cfg_regs #(.DW(DW)) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .first_dim_o  (first_dim),
    .second_dim_o (second_dim)
  );

  tcli_mulmod #(.DW(DW), .LW(LW)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (mm_m),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  tcli_seq #(.DW(DW), .LW(LW)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch_i      (in_ch_i),
    .out_ch_o     (out_ch_o),
    .first_dim_i  (first_dim),
    .second_dim_i (second_dim),
    .mm_start_o   (mm_start),
    .mm_x_o       (mm_x),
    .mm_y_o       (mm_y),
    .mm_m_o       (mm_m),
    .mm_done_i    (mm_done),
    .mm_res_i     (mm_res)
  );

endmodule

>>> src/tcli_cfg_regs.sv
// Dimension registers of the index engine, written through a plain write port.
// Depends on tcli_pkg for the register indices and port widths.
module tcli_cfg_regs
  import tcli_pkg::*;
#(
  parameter int unsigned DW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [DW-1:0]         first_dim_o,
  output logic [DW-1:0]         second_dim_o
);

  logic [DW-1:0] first_dim_q, first_dim_d;
  logic [DW-1:0] second_dim_q, second_dim_d;

  always_comb begin
    first_dim_d  = first_dim_q;
    second_dim_d = second_dim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIRST_DIM:  first_dim_d  = cfg_wdata_i[DW-1:0];
        REG_SECOND_DIM: second_dim_d = cfg_wdata_i[DW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_dim_q  <= DW'(1);
      second_dim_q <= DW'(1);
    end else begin
      first_dim_q  <= first_dim_d;
      second_dim_q <= second_dim_d;
    end
  end

  assign first_dim_o  = first_dim_q;
  assign second_dim_o = second_dim_q;

endmodule

>>> src/tcli_mulmod.sv
// Shared modular multiplier: x * y mod m by double-and-add, one modular add a cycle.
// Depends on tcli_pkg for the phase type.
module tcli_mulmod
  import tcli_pkg::*;
#(
  parameter int unsigned DW = 16,
  parameter int unsigned LW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [LW-1:0] x_i,      // must be below m
  input  logic [DW-1:0] y_i,
  input  logic [LW-1:0] m_i,      // held stable while busy
  output logic          done_o,   // one-cycle pulse, result valid with it
  output logic [LW-1:0] res_o
);

  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  mm_phase_e     phase_q, phase_d;
  logic [CW-1:0] bit_q, bit_d;
  logic [LW-1:0] r_q, r_d;
  logic [LW-1:0] x_q, x_d;
  logic [DW-1:0] y_q, y_d;

  logic [LW:0]   sum;
  logic [LW-1:0] r_mod;

  // (r + v) mod m with r, v below m: one add, one compare and subtract
  always_comb begin
    sum   = {1'b0, r_q} + {1'b0, (phase_q == MM_ADD) ? x_q : r_q};
    r_mod = (sum >= {1'b0, m_i}) ? LW'(sum - {1'b0, m_i}) : sum[LW-1:0];
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    bit_d   = bit_q;
    r_d     = r_q;
    x_d     = x_q;
    y_d     = y_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = MM_DBL;
      bit_d   = CW'(DW - 1);
      r_d     = '0;
      x_d     = x_i;
      y_d     = y_i;
    end else if (busy_q) begin
      r_d = r_mod;
      if (phase_q == MM_DBL && y_q[bit_q]) begin
        phase_d = MM_ADD;
      end else begin
        phase_d = MM_DBL;
        if (bit_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          bit_d = bit_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= MM_DBL;
      bit_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

>>> src/tcli_seq.sv
// Sequencer of the index engine: range check, forward and inverse maps, cycle walk,
// and the result register. Depends on tcli_pkg, tcli_if and the shared tcli_mulmod.
module tcli_seq
  import tcli_pkg::*;
#(
  parameter int unsigned DW = 16,
  parameter int unsigned LW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcli_in_if.sink       in_ch_i,
  tcli_out_if.source    out_ch_o,
  input  logic [DW-1:0] first_dim_i,
  input  logic [DW-1:0] second_dim_i,
  output logic          mm_start_o,
  output logic [LW-1:0] mm_x_o,
  output logic [DW-1:0] mm_y_o,
  output logic [LW-1:0] mm_m_o,
  input  logic          mm_done_i,
  input  logic [LW-1:0] mm_res_i
);

  seq_state_e state_q, state_d;

  logic [IDX_W-1:0] a_q, a_d;
  logic [LW-1:0]    prod_q, prod_d;
  logic [LW-1:0]    last_q, last_d;
  logic [LW-1:0]    fwd_q, fwd_d;
  logic [LW-1:0]    inv_q, inv_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic             lead_q, lead_d;
  logic             oor_q, oor_d;

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_fwd_q, out_fwd_d;
  logic [IDX_W-1:0] out_inv_q, out_inv_d;
  logic             out_lead_q, out_lead_d;
  logic             out_oor_q, out_oor_d;

  logic [LW-1:0]    a_l;
  logic             load_out;

  assign a_l = a_q[LW-1:0];

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    prod_d     = prod_q;
    last_d     = last_q;
    fwd_d      = fwd_q;
    inv_d      = inv_q;
    cur_d      = cur_q;
    lead_d     = lead_q;
    oor_d      = oor_q;
    mm_start_o = 1'b0;
    mm_x_o     = a_l;
    mm_y_o     = first_dim_i;
    load_out   = 1'b0;
    in_ch_i.ready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_ch_i.valid) begin
          a_d     = in_ch_i.elem_index;
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        prod_d  = LW'(first_dim_i) * LW'(second_dim_i);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // a zero dimension gives an empty matrix, so every index fails here
        if (a_q >= IDX_W'(prod_q)) begin
          fwd_d   = '0;
          inv_d   = '0;
          lead_d  = 1'b0;
          oor_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          last_d  = prod_q - LW'(1);
          oor_d   = 1'b0;
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (a_l == last_q) begin
          // last index is a fixed point of both maps
          fwd_d   = last_q;
          inv_d   = last_q;
          lead_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          mm_start_o = 1'b1;
          state_d    = S_FWD_WAIT;
        end
      end
      S_FWD_WAIT: begin
        if (mm_done_i) begin
          fwd_d      = mm_res_i;
          mm_start_o = 1'b1;
          mm_y_o     = second_dim_i;
          state_d    = S_INV_WAIT;
        end
      end
      S_INV_WAIT: begin
        if (mm_done_i) begin
          inv_d   = mm_res_i;
          cur_d   = fwd_q;
          state_d = S_WALK_TEST;
        end
      end
      S_WALK_TEST: begin
        if (cur_q == a_l) begin
          lead_d  = 1'b1;
          state_d = S_DONE;
        end else if (cur_q < a_l) begin
          lead_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          mm_start_o = 1'b1;
          mm_x_o     = cur_q;
          state_d    = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        if (mm_done_i) begin
          cur_d   = mm_res_i;
          state_d = S_WALK_TEST;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || out_ch_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign mm_m_o = last_q;

  always_comb begin
    out_valid_d = load_out | (out_valid_q & ~out_ch_o.ready);
    out_fwd_d   = out_fwd_q;
    out_inv_d   = out_inv_q;
    out_lead_d  = out_lead_q;
    out_oor_d   = out_oor_q;
    if (load_out) begin
      out_fwd_d  = IDX_W'(fwd_q);
      out_inv_d  = IDX_W'(inv_q);
      out_lead_d = lead_q;
      out_oor_d  = oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    prod_q     <= prod_d;
    last_q     <= last_d;
    fwd_q      <= fwd_d;
    inv_q      <= inv_d;
    cur_q      <= cur_d;
    lead_q     <= lead_d;
    oor_q      <= oor_d;
    out_fwd_q  <= out_fwd_d;
    out_inv_q  <= out_inv_d;
    out_lead_q <= out_lead_d;
    out_oor_q  <= out_oor_d;
  end

  assign out_ch_o.valid         = out_valid_q;
  assign out_ch_o.forward_index = out_fwd_q;
  assign out_ch_o.inverse_index = out_inv_q;
  assign out_ch_o.is_leader     = out_lead_q;
  assign out_ch_o.out_of_range  = out_oor_q;

endmodule
